[hdl/voice_frame_loss_concealer_assert.svh]
// Assertion macros shared by the frame loss concealer RTL.
`ifndef VOICE_FRAME_LOSS_CONCEALER_ASSERT_SVH
`define VOICE_FRAME_LOSS_CONCEALER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define VFLC_ASSERT_IMP(label, clk_sig, rstn_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (!(rstn_sig)) (ante) |-> (cons)) \
    else $error("vflc: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define VFLC_ASSERT_NXT(label, clk_sig, rstn_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (!(rstn_sig)) (ante) |=> (cons)) \
    else $error("vflc: next-cycle check failed");

`endif

[hdl/vflc_pkg.sv]
// Package for the voice frame loss concealer: codes, types and reset values.
package vflc_pkg;

  // Poll codes on the input channel; the unused code acts as an empty poll.
  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_HEADER = 2'd1;
  localparam logic [1:0] OP_DATA   = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_SILENCE = 2'd0;
  localparam logic [1:0] KIND_VOICE   = 2'd1;
  localparam logic [1:0] KIND_CONTROL = 2'd2;

  // Slow data decoder actions.
  localparam logic [2:0] SLOW_NONE  = 3'd0;
  localparam logic [2:0] SLOW_SYNC  = 3'd1;
  localparam logic [2:0] SLOW_ADD   = 3'd2;
  localparam logic [2:0] SLOW_NULL  = 3'd3;
  localparam logic [2:0] SLOW_RESET = 3'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MISSED_TICKS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HANG_ITER    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WD_LIMIT     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP      = 8'd3;

  // Register reset values.
  localparam logic [7:0]  RST_MISSED_TICKS = 8'd8;
  localparam logic [7:0]  RST_HANG_ITER    = 8'd30;
  localparam logic [15:0] RST_WD_LIMIT     = 16'd100;
  localparam logic [4:0]  RST_MAX_GAP      = 5'd18;

  // Sequence numbering and the longest gap that still fits one item's results.
  localparam int unsigned DEF_SEQ_MODULUS = 21;
  localparam logic [5:0]  MAX_FILL        = 6'd19;
  localparam logic [1:0]  HDR_LAST        = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_HDR,
    S_FILL,
    S_REAL,
    S_MISS,
    S_WDOG,
    S_HANG
  } fsm_state_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] vlo;
    logic [7:0]  vhi;
    logic [2:0]  act;
    logic [23:0] slow;
    logic        start_decode;
    logic        go_idle;
    logic        rx_reset;
    logic        busy_now;
    logic        last;
  } result_t;

endpackage

[hdl/voice_frame_loss_concealer.sv]
// Voice frame loss concealer: poll sequencer with gap filling and receiver timeouts.
// An input transfer is captured, decoded in S_DECODE, and its first result is then registered.
// One result per cycle while out_ready allows, from a single shared modulo incrementer and a
// gap counter; an item yields at most 21 results and a new poll is taken only in S_IDLE.
// Reset (rst_n low, synchronous) restores register defaults and clears state but not the payload.
module voice_frame_loss_concealer #(
  parameter int unsigned SEQ_MODULUS = vflc_pkg::DEF_SEQ_MODULUS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vflc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_op,
  input  logic [7:0]                     in_seq_byte,
  input  logic [63:0]                    in_voice_low,
  input  logic [7:0]                     in_voice_high,
  input  logic [23:0]                    in_slow_bytes,
  input  logic                           in_timebase_tick,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_frame_kind,
  output logic [63:0]                    out_voice_out_low,
  output logic [7:0]                     out_voice_out_high,
  output logic [2:0]                     out_slow_action,
  output logic [23:0]                    out_slow_out,
  output logic                           out_start_decode,
  output logic                           out_go_idle,
  output logic                           out_receiver_reset,
  output logic                           out_busy_now,
  output logic                           out_last
);

  localparam logic [5:0] ModW   = 6'(SEQ_MODULUS);
  localparam logic [4:0] SeqTop = 5'(SEQ_MODULUS - 1);

  // Configuration registers
  logic [7:0]  ticks_r, hang_iter_r;
  logic [15:0] wd_limit_r;
  logic [4:0]  max_gap_r;

  // Captured input payload
  logic [1:0]  op_r;
  logic [7:0]  seq_r;
  logic [63:0] vlo_r;
  logic [7:0]  vhi_r;
  logic [23:0] slow_r;

  // Receiver state
  vflc_pkg::fsm_state_t state_r, state_nxt;
  logic [4:0]  exp_r, exp_nxt;
  logic [7:0]  missed_r, missed_nxt;
  logic [7:0]  hang_r, hang_nxt;
  logic [15:0] wd_cnt_r, wd_cnt_nxt;
  logic        wd_run_r, wd_run_nxt;
  logic        busy_r, busy_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        wd_fire_r, wd_fire_nxt;
  logic        hang_fire_r, hang_fire_nxt;

  // Output register
  logic              out_valid_r;
  vflc_pkg::result_t res_r, res_nxt;
  logic              emitting;

  logic        in_xfer, emit_ok;
  logic [4:0]  seq_num;
  logic        end_bit, in_range, gap_ok, tail_done;
  logic [5:0]  gap;
  logic [7:0]  missed_inc, hang_post;
  logic        dec_wd_fire, dec_hang_fire;
  logic [4:0]  inc_src, inc_out;
  vflc_pkg::fsm_state_t tail_state, dec_tail_state;

  assign in_xfer   = in_valid && in_ready;
  assign in_ready  = (state_r == vflc_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign emit_ok   = !out_valid_r || out_ready;

  // Sequence number decode and gap to the expected number.
  assign seq_num  = seq_r[4:0];
  assign end_bit  = seq_r[6];
  assign in_range = ({1'b0, seq_num} < ModW);
  always_comb begin
    if (seq_num >= exp_r) begin
      gap = {1'b0, seq_num} - {1'b0, exp_r};
    end else begin
      gap = {1'b0, seq_num} + ModW - {1'b0, exp_r};
    end
  end
  assign gap_ok = (gap <= {1'b0, max_gap_r}) && (gap <= vflc_pkg::MAX_FILL);

  // Shared modulo incrementer: the received number on the real frame, else the expected one.
  assign inc_src = (state_r == vflc_pkg::S_REAL) ? seq_num : exp_r;
  assign inc_out = (inc_src == SeqTop) ? 5'd0 : inc_src + 5'd1;

  // Timeout outcome of the item, known once the poll is decoded.
  assign missed_inc  = missed_r + 8'd1;
  assign dec_wd_fire = (op_r != vflc_pkg::OP_HEADER) && (op_r != vflc_pkg::OP_DATA) &&
                       wd_run_r && (wd_limit_r != 16'd0) && (wd_cnt_r >= wd_limit_r);
  always_comb begin
    unique case (op_r)
      vflc_pkg::OP_HEADER: hang_post = 8'd0;
      vflc_pkg::OP_DATA:   hang_post = end_bit ? hang_iter_r : 8'd0;
      default:             hang_post = hang_r;
    endcase
  end
  assign dec_hang_fire = (hang_post == 8'd1);

  always_comb begin
    priority if (dec_wd_fire) begin
      dec_tail_state = vflc_pkg::S_WDOG;
    end else if (dec_hang_fire) begin
      dec_tail_state = vflc_pkg::S_HANG;
    end else begin
      dec_tail_state = vflc_pkg::S_IDLE;
    end
  end

  always_comb begin
    priority if (wd_fire_r) begin
      tail_state = vflc_pkg::S_WDOG;
    end else if (hang_fire_r) begin
      tail_state = vflc_pkg::S_HANG;
    end else begin
      tail_state = vflc_pkg::S_IDLE;
    end
  end
  assign tail_done = !wd_fire_r && !hang_fire_r;

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vflc_pkg::S_IDLE: begin
        if (in_xfer) state_nxt = vflc_pkg::S_DECODE;
      end
      vflc_pkg::S_DECODE: begin
        unique case (op_r)
          vflc_pkg::OP_HEADER: state_nxt = vflc_pkg::S_HDR;
          vflc_pkg::OP_DATA: begin
            if (end_bit || !in_range || !gap_ok) begin
              state_nxt = dec_tail_state;
            end else if (gap == 6'd0) begin
              state_nxt = vflc_pkg::S_REAL;
            end else begin
              state_nxt = vflc_pkg::S_FILL;
            end
          end
          default: begin
            if (busy_r && (missed_inc == ticks_r)) begin
              state_nxt = vflc_pkg::S_MISS;
            end else begin
              state_nxt = dec_tail_state;
            end
          end
        endcase
      end
      vflc_pkg::S_HDR: begin
        if (emit_ok && (cnt_r[1:0] == vflc_pkg::HDR_LAST)) state_nxt = tail_state;
      end
      vflc_pkg::S_FILL: begin
        if (emit_ok && (cnt_r == 5'd1)) state_nxt = vflc_pkg::S_REAL;
      end
      vflc_pkg::S_REAL, vflc_pkg::S_MISS: begin
        if (emit_ok) state_nxt = tail_state;
      end
      vflc_pkg::S_WDOG: begin
        if (emit_ok) state_nxt = hang_fire_r ? vflc_pkg::S_HANG : vflc_pkg::S_IDLE;
      end
      vflc_pkg::S_HANG: begin
        if (emit_ok) state_nxt = vflc_pkg::S_IDLE;
      end
      default: state_nxt = vflc_pkg::S_IDLE;
    endcase
  end

  // Receiver state updates.
  always_comb begin
    exp_nxt       = exp_r;
    missed_nxt    = missed_r;
    hang_nxt      = hang_r;
    wd_cnt_nxt    = wd_cnt_r;
    wd_run_nxt    = wd_run_r;
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    wd_fire_nxt   = wd_fire_r;
    hang_fire_nxt = hang_fire_r;
    unique case (state_r)
      vflc_pkg::S_IDLE: begin
        // The timebase tick advances a running watchdog before the poll is handled.
        if (in_xfer && in_timebase_tick && wd_run_r && (wd_cnt_r != 16'hFFFF)) begin
          wd_cnt_nxt = wd_cnt_r + 16'd1;
        end
      end
      vflc_pkg::S_DECODE: begin
        wd_fire_nxt   = dec_wd_fire;
        hang_fire_nxt = dec_hang_fire;
        hang_nxt      = (hang_post == 8'd0) ? 8'd0 : hang_post - 8'd1;
        unique case (op_r)
          vflc_pkg::OP_HEADER: begin
            busy_nxt   = 1'b1;
            exp_nxt    = 5'd0;
            wd_run_nxt = 1'b1;
            wd_cnt_nxt = 16'd0;
            missed_nxt = 8'd0;
            cnt_nxt    = 5'd0;
          end
          vflc_pkg::OP_DATA: begin
            wd_cnt_nxt = 16'd0;
            missed_nxt = 8'd0;
            cnt_nxt    = gap[4:0];
          end
          default: begin
            if (busy_r) begin
              missed_nxt = (missed_inc == ticks_r) ? 8'd0 : missed_inc;
            end
          end
        endcase
      end
      vflc_pkg::S_HDR: begin
        if (emit_ok) cnt_nxt = cnt_r + 5'd1;
      end
      vflc_pkg::S_FILL: begin
        if (emit_ok) begin
          cnt_nxt = cnt_r - 5'd1;
          exp_nxt = inc_out;
        end
      end
      vflc_pkg::S_REAL, vflc_pkg::S_MISS: begin
        if (emit_ok) exp_nxt = inc_out;
      end
      vflc_pkg::S_WDOG, vflc_pkg::S_HANG: begin
        if (emit_ok) begin
          busy_nxt   = 1'b0;
          wd_run_nxt = 1'b0;
          wd_cnt_nxt = 16'd0;
        end
      end
      default: ;
    endcase
  end

  // Result built for the current sequencer state.
  always_comb begin
    res_nxt          = '0;
    emitting         = 1'b0;
    res_nxt.busy_now = busy_r;
    unique case (state_r)
      vflc_pkg::S_HDR: begin
        emitting             = 1'b1;
        res_nxt.kind         = vflc_pkg::KIND_SILENCE;
        res_nxt.start_decode = (cnt_r == 5'd0);
        res_nxt.act          = (cnt_r[1:0] == vflc_pkg::HDR_LAST) ? vflc_pkg::SLOW_RESET
                                                                  : vflc_pkg::SLOW_NONE;
        res_nxt.last         = (cnt_r[1:0] == vflc_pkg::HDR_LAST) && tail_done;
      end
      vflc_pkg::S_FILL, vflc_pkg::S_MISS: begin
        emitting     = 1'b1;
        res_nxt.kind = vflc_pkg::KIND_SILENCE;
        res_nxt.act  = (exp_r == 5'd0) ? vflc_pkg::SLOW_SYNC : vflc_pkg::SLOW_NULL;
        res_nxt.last = (state_r == vflc_pkg::S_MISS) && tail_done;
      end
      vflc_pkg::S_REAL: begin
        emitting     = 1'b1;
        res_nxt.kind = vflc_pkg::KIND_VOICE;
        res_nxt.vlo  = vlo_r;
        res_nxt.vhi  = vhi_r;
        res_nxt.act  = (seq_num == 5'd0) ? vflc_pkg::SLOW_SYNC : vflc_pkg::SLOW_ADD;
        res_nxt.slow = (seq_num == 5'd0) ? 24'd0 : slow_r;
        res_nxt.last = tail_done;
      end
      vflc_pkg::S_WDOG, vflc_pkg::S_HANG: begin
        emitting         = 1'b1;
        res_nxt.kind     = vflc_pkg::KIND_CONTROL;
        res_nxt.act      = vflc_pkg::SLOW_RESET;
        res_nxt.go_idle  = 1'b1;
        res_nxt.rx_reset = 1'b1;
        res_nxt.busy_now = 1'b0;
        res_nxt.last     = (state_r == vflc_pkg::S_HANG) || !hang_fire_r;
      end
      default: ;
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vflc_pkg::S_IDLE;
      exp_r       <= 5'd0;
      missed_r    <= 8'd0;
      hang_r      <= 8'd0;
      wd_cnt_r    <= 16'd0;
      wd_run_r    <= 1'b0;
      busy_r      <= 1'b0;
      cnt_r       <= 5'd0;
      wd_fire_r   <= 1'b0;
      hang_fire_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_r       <= exp_nxt;
      missed_r    <= missed_nxt;
      hang_r      <= hang_nxt;
      wd_cnt_r    <= wd_cnt_nxt;
      wd_run_r    <= wd_run_nxt;
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      wd_fire_r   <= wd_fire_nxt;
      hang_fire_r <= hang_fire_nxt;
      if (emitting && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Configuration registers take a write on every transfer to their index; other indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r     <= vflc_pkg::RST_MISSED_TICKS;
      hang_iter_r <= vflc_pkg::RST_HANG_ITER;
      wd_limit_r  <= vflc_pkg::RST_WD_LIMIT;
      max_gap_r   <= vflc_pkg::RST_MAX_GAP;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == vflc_pkg::REG_MISSED_TICKS) ticks_r     <= cfg_data[7:0];
      if (cfg_index == vflc_pkg::REG_HANG_ITER)    hang_iter_r <= cfg_data[7:0];
      if (cfg_index == vflc_pkg::REG_WD_LIMIT)     wd_limit_r  <= cfg_data;
      if (cfg_index == vflc_pkg::REG_MAX_GAP)      max_gap_r   <= cfg_data[4:0];
    end
  end

  // Payload registers: input capture and the result register.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r   <= in_op;
      seq_r  <= in_seq_byte;
      vlo_r  <= in_voice_low;
      vhi_r  <= in_voice_high;
      slow_r <= in_slow_bytes;
    end
    if (emitting && emit_ok) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_kind     = res_r.kind;
  assign out_voice_out_low  = res_r.vlo;
  assign out_voice_out_high = res_r.vhi;
  assign out_slow_action    = res_r.act;
  assign out_slow_out       = res_r.slow;
  assign out_start_decode   = res_r.start_decode;
  assign out_go_idle        = res_r.go_idle;
  assign out_receiver_reset = res_r.rx_reset;
  assign out_busy_now       = res_r.busy_now;
  assign out_last           = res_r.last;

  // Checks on the sequencer.
  `include "voice_frame_loss_concealer_assert.svh"

  `VFLC_ASSERT_IMP(a_exp_in_range, clk, rst_n, 1'b1, ({1'b0, exp_r} < ModW))
  `VFLC_ASSERT_IMP(a_fill_count_live, clk, rst_n, (state_r == vflc_pkg::S_FILL), (cnt_r != 5'd0))
  `VFLC_ASSERT_NXT(a_real_sets_exp, clk, rst_n, (state_r == vflc_pkg::S_REAL) && emit_ok, (exp_r == $past(inc_out)))

endmodule
